// ===== rtl/core/bsdq_pkg.sv =====
// Shared types and constants for the bounded sequence deque.
`default_nettype none
package bsdq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_MID   = 3'd1,
    REQ_INS_END   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_MID   = 3'd4,
    REQ_DEL_END   = 3'd5,
    REQ_DUMP      = 3'd6,
    REQ_NOP       = 3'd7
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_req;
    logic do_edit;
    logic dump_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_nop;
    logic req_dump;
    logic dump_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/bsdq_ctrl.sv =====
// Request sequencer for the bounded sequence deque.
`default_nettype none
module bsdq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  bsdq_pkg::sts_t   sts,
  output bsdq_pkg::cmd_t   cmd,
  output logic             in_stall
);

  bsdq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsdq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bsdq_pkg::S_EXEC;
      end
      bsdq_pkg::S_EXEC: begin
        if (sts.req_nop) state_nxt = bsdq_pkg::S_IDLE;
        else if (sts.req_dump) state_nxt = bsdq_pkg::S_DUMP;
        else if (sts.out_free) state_nxt = bsdq_pkg::S_IDLE;
      end
      bsdq_pkg::S_DUMP: begin
        if (sts.out_free && sts.dump_last) state_nxt = bsdq_pkg::S_IDLE;
      end
      default: state_nxt = bsdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      bsdq_pkg::S_IDLE: begin
        in_stall      = 1'b0;
        cmd.latch_req = in_valid;
      end
      bsdq_pkg::S_EXEC: begin
        cmd.do_edit = !sts.req_nop && !sts.req_dump && sts.out_free;
      end
      bsdq_pkg::S_DUMP: begin
        cmd.dump_emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsdq_dpath.sv =====
// Shift-cell store, request decode and result register for the deque.
`default_nettype none
module bsdq_dpath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  bsdq_pkg::cmd_t                       cmd,
  output bsdq_pkg::sts_t                       sts,
  input  wire  [2:0]                           in_req_type,
  input  wire  signed [bsdq_pkg::DATA_W-1:0]   in_value_in,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           out_status,
  output logic signed [bsdq_pkg::DATA_W-1:0]   out_value_out,
  output logic [bsdq_pkg::CNT_W-1:0]           out_count,
  output logic                                 out_last
);

  logic [2:0]                         req_r;
  logic [bsdq_pkg::DATA_W-1:0]        val_r;
  logic [bsdq_pkg::CNT_W-1:0]         len_r, len_nxt;
  logic [bsdq_pkg::IDX_W-1:0]         idx_r;
  logic [bsdq_pkg::DATA_W-1:0]        cells_r   [bsdq_pkg::CAPACITY];
  logic [bsdq_pkg::DATA_W-1:0]        cells_nxt [bsdq_pkg::CAPACITY];

  logic                               out_valid_r;
  logic [1:0]                         out_status_r;
  logic [bsdq_pkg::DATA_W-1:0]        out_value_r;
  logic [bsdq_pkg::CNT_W-1:0]         out_count_r;
  logic                               out_last_r;

  logic is_ins, is_del, full, empty, ins_go, del_go;
  logic [bsdq_pkg::CNT_W-1:0] pos, len_m1;
  logic [bsdq_pkg::IDX_W-1:0] rd_idx;
  logic [bsdq_pkg::DATA_W-1:0] rd_val;

  assign full   = (len_r == bsdq_pkg::CNT_W'(bsdq_pkg::CAPACITY));
  assign empty  = (len_r == '0);
  assign len_m1 = len_r - bsdq_pkg::CNT_W'(1);

  // Decode the held request into a kind and a position
  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    pos    = '0;
    case (req_r)
      bsdq_pkg::REQ_INS_FRONT: begin
        is_ins = 1'b1;
      end
      bsdq_pkg::REQ_INS_MID: begin
        is_ins = 1'b1;
        pos    = empty ? '0 : (len_m1 >> 1) + bsdq_pkg::CNT_W'(1);
      end
      bsdq_pkg::REQ_INS_END: begin
        is_ins = 1'b1;
        pos    = len_r;
      end
      bsdq_pkg::REQ_DEL_FRONT: begin
        is_del = 1'b1;
      end
      bsdq_pkg::REQ_DEL_MID: begin
        is_del = 1'b1;
        pos    = len_m1 >> 1;
      end
      bsdq_pkg::REQ_DEL_END: begin
        is_del = 1'b1;
        pos    = len_m1;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  assign ins_go = cmd.do_edit && is_ins && !full;
  assign del_go = cmd.do_edit && is_del && !empty;

  // One read port: dump index while listing, edit position otherwise
  assign rd_idx = cmd.dump_emit ? idx_r : pos[bsdq_pkg::IDX_W-1:0];
  assign rd_val = cells_r[rd_idx];

  // Per-cell shift logic
  for (genvar i = 0; i < bsdq_pkg::CAPACITY; i++) begin : g_cell
    logic [bsdq_pkg::DATA_W-1:0] from_lo, from_hi;
    logic [bsdq_pkg::CNT_W-1:0]  here;
    assign here = bsdq_pkg::CNT_W'(i);
    if (i == 0) begin : g_lo0
      assign from_lo = cells_r[0];
    end else begin : g_lo
      assign from_lo = cells_r[i-1];
    end
    if (i == bsdq_pkg::CAPACITY - 1) begin : g_hi0
      assign from_hi = cells_r[i];
    end else begin : g_hi
      assign from_hi = cells_r[i+1];
    end
    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (ins_go) begin
        if (here == pos) cells_nxt[i] = val_r;
        else if (here > pos && here <= len_r) cells_nxt[i] = from_lo;
      end else if (del_go) begin
        if (here >= pos && here < len_m1) cells_nxt[i] = from_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < bsdq_pkg::CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (ins_go) len_nxt = len_r + bsdq_pkg::CNT_W'(1);
    else if (del_go) len_nxt = len_m1;
  end

  // Request hold and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= '0;
    end else begin
      len_r <= len_nxt;
      if (cmd.latch_req) idx_r <= '0;
      else if (cmd.dump_emit) idx_r <= idx_r + bsdq_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_req_type;
      val_r <= in_value_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_edit || cmd.dump_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_emit) begin
      out_status_r <= bsdq_pkg::ST_OK;
      out_value_r  <= rd_val;
      out_count_r  <= len_r;
      out_last_r   <= sts.dump_last;
    end else if (cmd.do_edit) begin
      out_last_r  <= 1'b1;
      out_value_r <= '0;
      out_count_r <= len_nxt;
      if (is_ins) begin
        out_status_r <= full ? bsdq_pkg::ST_FULL : bsdq_pkg::ST_OK;
      end else if (is_del && !empty) begin
        out_status_r <= bsdq_pkg::ST_OK;
        out_value_r  <= rd_val;
      end else begin
        out_status_r <= bsdq_pkg::ST_EMPTY;
      end
    end
  end

  assign sts.req_nop   = (req_r == bsdq_pkg::REQ_NOP);
  assign sts.req_dump  = (req_r == bsdq_pkg::REQ_DUMP) && !empty;
  assign sts.dump_last = ((bsdq_pkg::CNT_W'(idx_r) + bsdq_pkg::CNT_W'(1)) == len_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_sequence_deque_mid_ops.sv =====
// Top level of the bounded sequence deque with middle insert and delete.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request: in_req_type
//   selects insert front, middle or end, delete front, middle or end, or dump;
//   in_value_in is the value to insert. Results leave on the output channel
//   (out_valid / out_stall) with status, value, entry count and a last mark.
//   A request is taken in the idle state and held; the edit and its result
//   register update follow in the execute state. A dump is accepted, decoded,
//   then streams one entry per cycle while the receiver does not stall, with
//   last set on the final one.
//   The shift cells update all positions in the edit cycle; the single cell
//   read port and sequencer set the one-entry-per-cycle unstalled dump rate.
//   Request code 7 is dropped with no result.
//   Reset (rst_n low, synchronous) empties the store and clears the result
//   valid flag; cell contents are not cleared and are never read before write.
//   When the receiver stalls, the result register holds its value and the
//   sequencer waits; a new request is still accepted while a finished result
//   sits in the output register.
`default_nettype none
module bounded_sequence_deque_mid_ops (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [2:0]                         in_req_type,
  input  wire  signed [bsdq_pkg::DATA_W-1:0] in_value_in,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         out_status,
  output logic signed [bsdq_pkg::DATA_W-1:0] out_value_out,
  output logic [bsdq_pkg::CNT_W-1:0]         out_count,
  output logic                               out_last
);

  bsdq_pkg::cmd_t cmd;
  bsdq_pkg::sts_t sts;

  // Sequencer: accept, execute, stream dump entries
  bsdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Store, decode and result register
  bsdq_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_req_type),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_count     (out_count),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bsdq_chk.sv =====
// Port-level checker for the bounded sequence deque, bound to the top level.
`default_nettype none
module bsdq_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire [1:0]                          out_status,
  input wire signed [bsdq_pkg::DATA_W-1:0]  out_value_out,
  input wire [bsdq_pkg::CNT_W-1:0]          out_count,
  input wire                                out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out)
      && $stable(out_count) && $stable(out_last) && $stable(out_status))
    else $error("stalled result changed");

  // One request at a time: the block stalls right after taking a request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bsdq_pkg::ST_FULL |->
      out_count == bsdq_pkg::CNT_W'(bsdq_pkg::CAPACITY) && out_last)
    else $error("full status with wrong count");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bsdq_pkg::ST_EMPTY |->
      out_count == '0 && out_value_out == '0 && out_last)
    else $error("empty status with wrong fields");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= bsdq_pkg::CNT_W'(bsdq_pkg::CAPACITY))
    else $error("count above capacity");

endmodule

bind bounded_sequence_deque_mid_ops bsdq_chk u_bsdq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_value_out (out_value_out),
  .out_count     (out_count),
  .out_last      (out_last)
);
`default_nettype wire

// ===== test/tb_bounded_sequence_deque_mid_ops.sv =====
// Self-checking testbench for the bounded sequence deque with middle insert and delete.
`timescale 1ns / 100ps
module tb_bounded_sequence_deque_mid_ops;
  import bsdq_pkg::*;

  // Code 7 is not part of the request set; the block must drop it silently.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int RAND_REQUESTS = 320;
  localparam int DRAIN_CYCLES  = 40;   // longer than an unstalled full dump of CAPACITY entries
  localparam int MAX_REPORTS   = 200;

  // One result as the block should present it.
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              is_last;
  } result_t;

  // One line of the directed plan. Rows with a typed-in result use it in place
  // of the shadow store's prediction; the shadow still tracks the contents.
  typedef struct {
    logic [2:0]        req;
    logic [DATA_W-1:0] val;
    int                reps;
    bit                typed;
    result_t           want;
  } plan_row_t;

  localparam int PLAN_ROWS = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = 3'd0;
  logic signed [DATA_W-1:0] in_value_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [DATA_W-1:0] out_value_out;
  logic [CNT_W-1:0] out_count;
  logic out_last;

  // Shadow copy of the stored sequence, index 0 at the front.
  logic [DATA_W-1:0] shadow_seq[$];
  // Results still owed by the block, oldest first.
  result_t pending_results[$];
  result_t head_result;
  int mismatch_count = 0;
  // When set, both sides run back to back with no idle cycles.
  bit no_idle = 1'b0;

  plan_row_t plan [PLAN_ROWS];

  bounded_sequence_deque_mid_ops uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_count     (out_count),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic int idle_cycles();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Queue one expected result; the count field reflects the shadow after the edit.
  function automatic void owe_result(input status_t st, input logic [DATA_W-1:0] v,
                                     input logic lst);
    result_t r;
    r.status  = st;
    r.value   = v;
    r.count   = CNT_W'(shadow_seq.size());
    r.is_last = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow store and queue what it causes.
  function automatic void apply_request(input logic [2:0] req, input logic [DATA_W-1:0] v);
    int n;
    int pos;
    logic [DATA_W-1:0] taken;
    n = shadow_seq.size();
    case (req)
      REQ_INS_FRONT, REQ_INS_MID, REQ_INS_END: begin
        if (n >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          if (req == REQ_INS_FRONT) pos = 0;
          else if (req == REQ_INS_END) pos = n;
          else pos = (n == 0) ? 0 : (n - 1) / 2 + 1;
          shadow_seq.insert(pos, v);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DEL_FRONT, REQ_DEL_MID, REQ_DEL_END: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (req == REQ_DEL_FRONT) pos = 0;
          else if (req == REQ_DEL_END) pos = n - 1;
          else pos = (n - 1) / 2;
          taken = shadow_seq[pos];
          shadow_seq.delete(pos);
          owe_result(ST_OK, taken, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) owe_result(ST_OK, shadow_seq[i], i == n - 1);
        end
      end
      default: begin
        // unused code: drop, nothing owed
      end
    endcase
  endfunction

  // Present one request after a random gap, hold it until taken, then predict.
  // Returns in the time step of the accepting edge, with in_valid still high.
  task automatic issue_request(input logic [2:0] req, input logic [DATA_W-1:0] v);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value_in <= v;
    do @(posedge clk); while (in_stall);
    apply_request(req, v);
  endtask

  // Result checker: compare every taken result with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %h count %0d last %0b",
                                  out_status, out_value_out, out_count, out_last));
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, head_result.status));
        if (out_value_out !== head_result.value)
          report_mismatch($sformatf("value %h, want %h", out_value_out, head_result.value));
        if (out_count !== head_result.count)
          report_mismatch($sformatf("count %0d, want %0d", out_count, head_result.count));
        if (out_last !== head_result.is_last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, head_result.is_last));
      end
    end
  end

  // Receiver: before each result, stall for a random number of cycles.
  initial begin
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Request driver: directed plan first, then random traffic, then drain.
  initial begin
    int done;
    int roll;
    bit grow;
    logic [2:0] req;
    logic [DATA_W-1:0] v;

    // Empty-store errors, the dropped code, value extremes, filling to
    // capacity, inserts into a full store and a full-length dump.
    plan = '{
      '{REQ_DUMP,      32'h0000_0000, 1, 1'b1, '{ST_EMPTY, 32'h0,  5'd0, 1'b1}},
      '{REQ_DEL_FRONT, 32'h0000_0000, 1, 1'b1, '{ST_EMPTY, 32'h0,  5'd0, 1'b1}},
      '{REQ_DEL_MID,   32'hFFFF_FFFF, 1, 1'b1, '{ST_EMPTY, 32'h0,  5'd0, 1'b1}},
      '{REQ_DEL_END,   32'h0000_0000, 1, 1'b1, '{ST_EMPTY, 32'h0,  5'd0, 1'b1}},
      '{REQ_UNUSED,    32'hFFFF_FFFF, 1, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_INS_MID,   32'h7FFF_FFFF, 1, 1'b1, '{ST_OK,    32'h0,  5'd1, 1'b1}},
      '{REQ_INS_FRONT, 32'h8000_0000, 1, 1'b1, '{ST_OK,    32'h0,  5'd2, 1'b1}},
      '{REQ_INS_END,   32'hFFFF_FFFF, 1, 1'b1, '{ST_OK,    32'h0,  5'd3, 1'b1}},
      '{REQ_DEL_MID,   32'h0000_0000, 1, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_INS_MID,   32'h0000_0000, 1, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_INS_FRONT, 32'h0000_1000, 7, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_INS_END,   32'h0000_2000, 6, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_INS_MID,   32'h5555_AAAA, 1, 1'b1, '{ST_FULL,  32'h0,  5'd16, 1'b1}},
      '{REQ_INS_END,   32'h0000_0000, 1, 1'b1, '{ST_FULL,  32'h0,  5'd16, 1'b1}},
      '{REQ_DUMP,      32'h0000_0000, 1, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}},
      '{REQ_DEL_END,   32'h0000_0000, 1, 1'b0, '{ST_OK,    32'h0,  5'd0, 1'b0}}
    };

    // Hold reset low, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        issue_request(plan[r].req, plan[r].val + DATA_W'(k));
        if (plan[r].typed) begin
          // swap the predicted result for the typed-in one
          void'(pending_results.pop_back());
          pending_results.push_back(plan[r].want);
        end
      end
    end

    // Random traffic in alternating grow and shrink phases so the store runs
    // between empty and full; dropped codes do not count toward the total.
    done = 0;
    grow = 1'b1;
    while (done < RAND_REQUESTS) begin
      if (done % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (done % 50 == 0) grow = ~grow;
      roll = $urandom_range(0, 99);
      if (roll < 3) req = REQ_UNUSED;
      else if (roll < 13) req = REQ_DUMP;
      else if ($urandom_range(0, 99) < (grow ? 75 : 25)) req = 3'($urandom_range(0, 2));
      else req = 3'($urandom_range(3, 5));
      case ($urandom_range(0, 7))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h0000_0000;
        default: v = $urandom;
      endcase
      issue_request(req, v);
      if (req != REQ_UNUSED) done++;
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then give a dropped request time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bsdq_pkg.sv
rtl/core/bsdq_ctrl.sv
rtl/core/bsdq_dpath.sv
rtl/core/bounded_sequence_deque_mid_ops.sv
rtl/core/bsdq_chk.sv
test/tb_bounded_sequence_deque_mid_ops.sv
